/* sv/jamc_pkg.sv */
// ----------------------------------------------------------------------------
// jamc_pkg
// Shared types and constants for the joystick aim and move conditioner.
// ----------------------------------------------------------------------------
package jamc_pkg;

   // field widths
   localparam int OP_W       = 1;
   localparam int BTN_W      = 6;
   localparam int STICK_W    = 8;
   localparam int CNT_W      = 6;
   localparam int AIM_W      = 16;
   localparam int DIR_W      = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int AIM_DZ_W   = 7;
   localparam int MOVE_DZ_W  = 8;
   localparam int AIM_LEN_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_AIM_DEADZONE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_DEADZONE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AIM_LENGTH    = 2'd2;

   localparam logic [AIM_DZ_W-1:0]  AIM_DZ_RST  = 7'd12;
   localparam logic [MOVE_DZ_W-1:0] MOVE_DZ_RST = 8'd40;
   localparam logic [AIM_LEN_W-1:0] AIM_LEN_RST = 8'd120;
   localparam logic [AIM_W-1:0]     AIM_X_RST   = 16'd120;
   localparam logic [AIM_W-1:0]     AIM_Y_RST   = 16'd0;

   // opcodes
   localparam logic [OP_W-1:0] OP_APPLY = 1'b0;
   localparam logic [OP_W-1:0] OP_ADOPT = 1'b1;

   // button bit positions
   localparam int BTN_LEFT  = 0;
   localparam int BTN_RIGHT = 1;
   localparam int BTN_A     = 2;
   localparam int BTN_B     = 3;
   localparam int BTN_Z     = 4;
   localparam int BTN_R     = 5;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'b11;
   localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'b01;

   // aim datapath widths
   localparam int MAG_W     = 8;   // |stick| up to 128
   localparam int R2_W      = 16;  // x^2 + y^2 up to 32768
   localparam int PROD_W    = 16;  // |v| * length up to 32640
   localparam int T_W       = 30;  // (|v| * length)^2
   localparam int ACC_W     = 9;   // scaled axis magnitude 0..511
   localparam int SQ_W      = 2 * ACC_W;
   localparam int BIT_IDX_W = 4;

   localparam logic [BIT_IDX_W-1:0] ACC_TOP_BIT = 4'd8;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_A,
      ST_PREP_B,
      ST_SQUARE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 accept;
      logic                 prep_a;
      logic                 prep_b;
      logic                 square;
      logic                 compare;
      logic                 store_axis;
      logic                 axis;
      logic [BIT_IDX_W-1:0] bit_idx;
      logic                 load_rsp;
   } cmd_type;

   typedef struct packed {
      logic update_aim;
      logic rsp_busy;
   } sts_type;

   typedef struct packed {
      logic [OP_W-1:0]           opcode;
      logic [BTN_W-1:0]          buttons;
      logic signed [STICK_W-1:0] stick_x;
      logic signed [STICK_W-1:0] stick_y;
      logic [CNT_W-1:0]          load_fire;
      logic [CNT_W-1:0]          load_weapon;
      logic signed [AIM_W-1:0]   load_aim_x;
      logic signed [AIM_W-1:0]   load_aim_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] direction;
      logic signed [AIM_W-1:0] target_x;
      logic signed [AIM_W-1:0] target_y;
      logic                    jump;
      logic                    hook;
      logic [CNT_W-1:0]        fire_count;
      logic [CNT_W-1:0]        weapon_count;
   } rsp_payload_type;

endpackage

/* sv/jamc_req_if.sv */
// ----------------------------------------------------------------------------
// jamc_req_if
// Valid/ready channel carrying one joypad sample or adopt item.
// ----------------------------------------------------------------------------
interface jamc_req_if;

   logic                                  valid;
   logic                                  ready;
   logic [jamc_pkg::OP_W-1:0]             opcode;
   logic [jamc_pkg::BTN_W-1:0]            buttons;
   logic signed [jamc_pkg::STICK_W-1:0]   stick_x;
   logic signed [jamc_pkg::STICK_W-1:0]   stick_y;
   logic [jamc_pkg::CNT_W-1:0]            load_fire;
   logic [jamc_pkg::CNT_W-1:0]            load_weapon;
   logic signed [jamc_pkg::AIM_W-1:0]     load_aim_x;
   logic signed [jamc_pkg::AIM_W-1:0]     load_aim_y;

   modport source (
      output valid, opcode, buttons, stick_x, stick_y,
             load_fire, load_weapon, load_aim_x, load_aim_y,
      input  ready
   );

   modport sink (
      input  valid, opcode, buttons, stick_x, stick_y,
             load_fire, load_weapon, load_aim_x, load_aim_y,
      output ready
   );

endinterface

/* sv/jamc_rsp_if.sv */
// ----------------------------------------------------------------------------
// jamc_rsp_if
// Valid/ready channel carrying one conditioned result.
// ----------------------------------------------------------------------------
interface jamc_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [jamc_pkg::DIR_W-1:0]   direction;
   logic signed [jamc_pkg::AIM_W-1:0]   target_x;
   logic signed [jamc_pkg::AIM_W-1:0]   target_y;
   logic                                jump;
   logic                                hook;
   logic [jamc_pkg::CNT_W-1:0]          fire_count;
   logic [jamc_pkg::CNT_W-1:0]          weapon_count;

   modport source (
      output valid, direction, target_x, target_y, jump, hook,
             fire_count, weapon_count,
      input  ready
   );

   modport sink (
      input  valid, direction, target_x, target_y, jump, hook,
             fire_count, weapon_count,
      output ready
   );

endinterface

/* sv/joystick_aim_move_conditioner_unit.sv */
// An adopt item completes in its transfer cycle. A sample with the stick
// inside the aim deadzone runs the prep steps, then loads its result once
// the result register is free. A sample that updates the aim first searches
// 9 result bits per axis, each a square then a compare on the shared
// square/compare unit. One adopt item per cycle while no sample is in flight.
// Reset (synchronous): registers to 12/40/120, aim (120,0), counters 0.
// ----------------------------------------------------------------------------
// joystick_aim_move_conditioner_unit
// Top level: joins the sequencer and the datapath to the channels and the
// configuration write port.
// ----------------------------------------------------------------------------
module joystick_aim_move_conditioner_unit #(
   parameter int COUNTER_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   jamc_req_if.sink                          req_chan,
   jamc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [jamc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jamc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   jamc_pkg::cmd_type           cmd;
   jamc_pkg::sts_type           sts;
   jamc_pkg::req_payload_type   req;
   jamc_pkg::rsp_payload_type   rsp;
   logic                        req_ready;
   logic                        rsp_valid;

   // gather the request payload
   assign req.opcode      = req_chan.opcode;
   assign req.buttons     = req_chan.buttons;
   assign req.stick_x     = req_chan.stick_x;
   assign req.stick_y     = req_chan.stick_y;
   assign req.load_fire   = req_chan.load_fire;
   assign req.load_weapon = req_chan.load_weapon;
   assign req.load_aim_x  = req_chan.load_aim_x;
   assign req.load_aim_y  = req_chan.load_aim_y;
   assign req_chan.ready  = req_ready;

   jamc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jamc_dpath #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp)
   );

   // drive the result channel
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.direction    = rsp.direction;
   assign rsp_chan.target_x     = rsp.target_x;
   assign rsp_chan.target_y     = rsp.target_y;
   assign rsp_chan.jump         = rsp.jump;
   assign rsp_chan.hook         = rsp.hook;
   assign rsp_chan.fire_count   = rsp.fire_count;
   assign rsp_chan.weapon_count = rsp.weapon_count;

`ifndef SYNTHESIS
   // a finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && !rsp_chan.ready))
      else $error("result register overwritten while pending");

   // a sample transfer closes the input until its result is formed
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.opcode == jamc_pkg::OP_APPLY))
      |=> !req_chan.ready)
      else $error("input reopened during sample processing");

   // the sequencer issues at most one step command per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.prep_a, cmd.prep_b, cmd.square, cmd.compare,
                cmd.load_rsp}))
      else $error("conflicting datapath commands");

   // direction is never the unused code
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chan.direction != 2'b10))
      else $error("invalid direction code");
`endif

endmodule

/* sv/jamc_ctrl.sv */
// ----------------------------------------------------------------------------
// jamc_ctrl
// Sequencer: accepts items, walks the bit-by-bit aim search over both axes
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module jamc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [jamc_pkg::OP_W-1:0]    req_opcode,
   output logic                         req_ready,
   input  jamc_pkg::sts_type            sts,
   output jamc_pkg::cmd_type            cmd
);

   jamc_pkg::state_type                  state_ff, state_in;
   logic                                 axis_ff, axis_in;
   logic [jamc_pkg::BIT_IDX_W-1:0]       bit_ff, bit_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jamc_pkg::ST_IDLE;
         axis_ff  <= jamc_pkg::AXIS_X;
         bit_ff   <= jamc_pkg::ACC_TOP_BIT;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         bit_ff   <= bit_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      bit_in         = bit_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.axis       = axis_ff;
      cmd.bit_idx    = bit_ff;

      unique case (state_ff)
         jamc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            // adopt items finish in the transfer cycle
            if (req_valid && (req_opcode == jamc_pkg::OP_APPLY)) begin
               state_in = jamc_pkg::ST_PREP_A;
            end
         end
         jamc_pkg::ST_PREP_A: begin
            cmd.prep_a = 1'b1;
            state_in   = jamc_pkg::ST_PREP_B;
         end
         jamc_pkg::ST_PREP_B: begin
            cmd.prep_b = 1'b1;
            axis_in    = jamc_pkg::AXIS_X;
            bit_in     = jamc_pkg::ACC_TOP_BIT;
            if (sts.update_aim) begin
               state_in = jamc_pkg::ST_SQUARE;
            end else begin
               state_in = jamc_pkg::ST_FINISH;
            end
         end
         jamc_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = jamc_pkg::ST_COMPARE;
         end
         jamc_pkg::ST_COMPARE: begin
            cmd.compare = 1'b1;
            if (bit_ff == '0) begin
               // last bit of this axis: write it back, then next axis or done
               cmd.store_axis = 1'b1;
               if (axis_ff == jamc_pkg::AXIS_X) begin
                  axis_in  = jamc_pkg::AXIS_Y;
                  bit_in   = jamc_pkg::ACC_TOP_BIT;
                  state_in = jamc_pkg::ST_SQUARE;
               end else begin
                  state_in = jamc_pkg::ST_FINISH;
               end
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = jamc_pkg::ST_SQUARE;
            end
         end
         jamc_pkg::ST_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = jamc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jamc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/jamc_dpath.sv */
// ----------------------------------------------------------------------------
// jamc_dpath
// Datapath: configuration registers, counters, aim state, the shared
// square/compare unit of the aim search and the result register.
// ----------------------------------------------------------------------------
module jamc_dpath #(
   parameter int COUNTER_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [jamc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jamc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  jamc_pkg::req_payload_type         req,
   input  jamc_pkg::cmd_type                 cmd,
   output jamc_pkg::sts_type                 sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output jamc_pkg::rsp_payload_type         rsp
);

   localparam int MAG_W  = jamc_pkg::MAG_W;
   localparam int R2_W   = jamc_pkg::R2_W;
   localparam int PROD_W = jamc_pkg::PROD_W;
   localparam int T_W    = jamc_pkg::T_W;
   localparam int ACC_W  = jamc_pkg::ACC_W;
   localparam int SQ_W   = jamc_pkg::SQ_W;
   localparam int AIM_W  = jamc_pkg::AIM_W;
   localparam int DZ_W   = jamc_pkg::AIM_DZ_W;
   localparam int STICK_EXT_W = jamc_pkg::STICK_W + 2;

   // configuration
   logic [jamc_pkg::AIM_DZ_W-1:0]   aim_dz_ff, aim_dz_in;
   logic [jamc_pkg::MOVE_DZ_W-1:0]  move_dz_ff, move_dz_in;
   logic [jamc_pkg::AIM_LEN_W-1:0]  aim_len_ff, aim_len_in;

   // architectural state
   logic [AIM_W-1:0]                aim_x_ff, aim_x_in;
   logic [AIM_W-1:0]                aim_y_ff, aim_y_in;
   logic [COUNTER_BITS-1:0]         fire_ff, fire_in;
   logic [COUNTER_BITS-1:0]         weapon_ff, weapon_in;

   // per-item working registers
   logic [MAG_W-1:0]                mx_ff, mx_in, my_ff, my_in;
   logic                            neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [jamc_pkg::DIR_W-1:0]      dir_ff, dir_in;
   logic                            jump_ff, jump_in, hook_ff, hook_in;
   logic [R2_W-1:0]                 r2_ff, r2_in;
   logic [PROD_W-1:0]               px_ff, px_in, py_ff, py_in;
   logic [T_W-1:0]                  tx_ff, tx_in, ty_ff, ty_in;
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [SQ_W-1:0]                 sq_ff, sq_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   jamc_pkg::rsp_payload_type       rsp_ff, rsp_in;

   // combinational helpers
   logic [2*MAG_W-1:0]              sqx, sqy;
   logic [2*MAG_W-1:0]              px_prod, py_prod;
   logic [2*PROD_W-1:0]             tx_prod, ty_prod;
   logic [2*DZ_W-1:0]               dz_sq;
   logic [ACC_W-1:0]                cand, acc_next;
   logic [SQ_W-1:0]                 sq_prod;
   logic [SQ_W+R2_W-1:0]            trial;
   logic [T_W-1:0]                  t_sel;
   logic [AIM_W-1:0]                aim_mag, aim_val;
   logic signed [STICK_EXT_W-1:0]   sx_ext, mdz_ext;
   logic                            go_left, go_right;

   // shared arithmetic
   assign sqx     = mx_ff * mx_ff;
   assign sqy     = my_ff * my_ff;
   assign px_prod = mx_ff * aim_len_ff;
   assign py_prod = my_ff * aim_len_ff;
   assign tx_prod = px_ff * px_ff;
   assign ty_prod = py_ff * py_ff;
   assign dz_sq   = aim_dz_ff * aim_dz_ff;

   // one trial bit of the aim search: square, then scale by r2 and compare
   assign cand     = acc_ff | (ACC_W'(1) << cmd.bit_idx);
   assign sq_prod  = cand * cand;
   assign trial    = sq_ff * r2_ff;
   assign t_sel    = (cmd.axis == jamc_pkg::AXIS_Y) ? ty_ff : tx_ff;
   assign acc_next = (trial <= (SQ_W+R2_W)'(t_sel)) ? cand : acc_ff;

   // signed writeback of the finished axis
   assign aim_mag = AIM_W'(acc_next);
   always_comb begin
      if (cmd.axis == jamc_pkg::AXIS_Y) begin
         aim_val = neg_y_ff ? (~aim_mag + 1'b1) : aim_mag;
      end else begin
         aim_val = neg_x_ff ? (~aim_mag + 1'b1) : aim_mag;
      end
   end

   // walking direction from the D-pad or the stick past the move deadzone
   assign sx_ext   = {{2{req.stick_x[jamc_pkg::STICK_W-1]}}, req.stick_x};
   assign mdz_ext  = {2'b00, move_dz_ff};
   assign go_left  = req.buttons[jamc_pkg::BTN_LEFT] || (sx_ext <= -mdz_ext);
   assign go_right = req.buttons[jamc_pkg::BTN_RIGHT] || (sx_ext >= mdz_ext);

   assign sts.update_aim = (r2_ff != '0) && (r2_ff >= R2_W'(dz_sq));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // next values
   always_comb begin
      aim_dz_in    = aim_dz_ff;
      move_dz_in   = move_dz_ff;
      aim_len_in   = aim_len_ff;
      aim_x_in     = aim_x_ff;
      aim_y_in     = aim_y_ff;
      fire_in      = fire_ff;
      weapon_in    = weapon_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      dir_in       = dir_ff;
      jump_in      = jump_ff;
      hook_in      = hook_ff;
      r2_in        = r2_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // configuration writes; unknown indexes are dropped
      if (csr_we) begin
         unique case (csr_index)
            jamc_pkg::CSR_AIM_DEADZONE:  aim_dz_in  = csr_wdata[DZ_W-1:0];
            jamc_pkg::CSR_MOVE_DEADZONE: move_dz_in = csr_wdata;
            jamc_pkg::CSR_AIM_LENGTH:    aim_len_in = csr_wdata;
            default: begin
            end
         endcase
      end

      // item transfer
      if (cmd.accept) begin
         if (req.opcode == jamc_pkg::OP_ADOPT) begin
            fire_in   = COUNTER_BITS'(req.load_fire);
            weapon_in = COUNTER_BITS'(req.load_weapon);
            if ((req.load_aim_x != '0) || (req.load_aim_y != '0)) begin
               aim_x_in = req.load_aim_x;
               aim_y_in = req.load_aim_y;
            end
         end else begin
            // magnitudes; y is flipped so it is negative when the stick is up
            mx_in    = req.stick_x[jamc_pkg::STICK_W-1] ? (~req.stick_x + 1'b1)
                                                        : req.stick_x;
            my_in    = req.stick_y[jamc_pkg::STICK_W-1] ? (~req.stick_y + 1'b1)
                                                        : req.stick_y;
            neg_x_in = req.stick_x[jamc_pkg::STICK_W-1];
            neg_y_in = !req.stick_y[jamc_pkg::STICK_W-1] && (req.stick_y != '0);
            if (go_left && !go_right) begin
               dir_in = jamc_pkg::DIR_LEFT;
            end else if (go_right && !go_left) begin
               dir_in = jamc_pkg::DIR_RIGHT;
            end else begin
               dir_in = jamc_pkg::DIR_NONE;
            end
            jump_in = req.buttons[jamc_pkg::BTN_A];
            hook_in = req.buttons[jamc_pkg::BTN_Z];
            // press counters step when the level differs from the low bit
            if (fire_ff[0] != req.buttons[jamc_pkg::BTN_B]) begin
               fire_in = fire_ff + 1'b1;
            end
            if (weapon_ff[0] != req.buttons[jamc_pkg::BTN_R]) begin
               weapon_in = weapon_ff + 1'b1;
            end
         end
      end

      // radius squared and scaled magnitudes
      if (cmd.prep_a) begin
         r2_in = sqx + sqy;
         px_in = px_prod;
         py_in = py_prod;
      end

      // targets of the search
      if (cmd.prep_b) begin
         tx_in  = tx_prod[T_W-1:0];
         ty_in  = ty_prod[T_W-1:0];
         acc_in = '0;
      end

      if (cmd.square) begin
         sq_in = sq_prod;
      end

      if (cmd.compare) begin
         acc_in = acc_next;
         if (cmd.store_axis) begin
            acc_in = '0;
            if (cmd.axis == jamc_pkg::AXIS_Y) begin
               aim_y_in = aim_val;
            end else begin
               aim_x_in = aim_val;
            end
         end
      end

      // result register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in        = 1'b1;
         rsp_in.direction    = dir_ff;
         rsp_in.target_x     = aim_x_ff;
         rsp_in.target_y     = aim_y_ff;
         rsp_in.jump         = jump_ff;
         rsp_in.hook         = hook_ff;
         rsp_in.fire_count   = jamc_pkg::CNT_W'(fire_ff);
         rsp_in.weapon_count = jamc_pkg::CNT_W'(weapon_ff);
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         aim_dz_ff    <= jamc_pkg::AIM_DZ_RST;
         move_dz_ff   <= jamc_pkg::MOVE_DZ_RST;
         aim_len_ff   <= jamc_pkg::AIM_LEN_RST;
         aim_x_ff     <= jamc_pkg::AIM_X_RST;
         aim_y_ff     <= jamc_pkg::AIM_Y_RST;
         fire_ff      <= '0;
         weapon_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         aim_dz_ff    <= aim_dz_in;
         move_dz_ff   <= move_dz_in;
         aim_len_ff   <= aim_len_in;
         aim_x_ff     <= aim_x_in;
         aim_y_ff     <= aim_y_in;
         fire_ff      <= fire_in;
         weapon_ff    <= weapon_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      dir_ff   <= dir_in;
      jump_ff  <= jump_in;
      hook_ff  <= hook_in;
      r2_ff    <= r2_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* test/joystick_aim_move_conditioner_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_aim_move_conditioner_unit_tb
// Self-checking bench for the joystick conditioner. A directed table covers
// stick and button extremes, counter wrap, aim adoption and the deadzone
// corner cases; random samples follow under several register settings. The
// expected result of each sample transfer is the table's where it has one,
// else an in-bench conditioner's, compared field by field with the block's.
// ----------------------------------------------------------------------------
module joystick_aim_move_conditioner_unit_tb;

   import jamc_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 50;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 200;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_JITTER,
      SINK_WHEEL
   } sink_mode_type;

   // one line of the directed table: a register setting or a sample
   typedef struct {
      bit              retune;
      int unsigned     dz;
      int unsigned     md;
      int unsigned     len;
      req_payload_type item;
      bit              known;
      rsp_payload_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   jamc_req_if req_bus ();
   jamc_rsp_if rsp_bus ();

   joystick_aim_move_conditioner_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // bench copy of the block's registers and state
   int unsigned cfg_aim_dz;
   int unsigned cfg_move_dz;
   int unsigned cfg_aim_len;
   logic [AIM_W-1:0] aim_x;
   logic [AIM_W-1:0] aim_y;
   logic [CNT_W-1:0] fire_cnt;
   logic [CNT_W-1:0] weapon_cnt;

   rsp_payload_type pending_results [$];
   plan_row_type    directed_plan [$];
   int              mismatches = 0;
   int              quiet_cycles = 0;

   // sender burst shaping
   int              burst_left = 0;
   int              gap_left = 0;
   logic [BTN_W-1:0] held_buttons = '0;

   // receiver stall pattern
   sink_mode_type   sink_mode = SINK_OPEN;
   int              sink_left = 0;
   logic [11:0]     sink_wheel = 12'b1110_0000_1101;

   rsp_payload_type observed;

   // --- conditioner ---------------------------------------------------------

   // largest a with a*a*rad_sq <= (|v|*len)^2, signed like v
   function automatic logic [AIM_W-1:0] fit_axis(input int v, input longint unsigned rad_sq);
      longint unsigned mag;
      longint unsigned goal;
      longint unsigned trial;
      longint unsigned acc;
      int              b;
      mag  = (v < 0) ? longint'(-v) : longint'(v);
      goal = mag * cfg_aim_len;
      goal = goal * goal;
      acc  = 0;
      for (b = 8; b >= 0; b--) begin
         trial = acc | (64'd1 << b);
         if (trial * trial * rad_sq <= goal)
            acc = trial;
      end
      return (v < 0) ? AIM_W'(64'd0 - acc) : AIM_W'(acc);
   endfunction

   // press counter steps while the level disagrees with its low bit
   function automatic logic [CNT_W-1:0] press_count(input logic [CNT_W-1:0] c, input bit level);
      return (c[0] != level) ? c + 1'b1 : c;
   endfunction

   task automatic condition_item(input req_payload_type it, output bit gives,
                                 output rsp_payload_type r);
      int              sx;
      int              sy;
      int              dir;
      longint unsigned rad_sq;
      r     = '0;
      gives = 1'b0;
      if (it.opcode == OP_ADOPT) begin
         fire_cnt   = it.load_fire;
         weapon_cnt = it.load_weapon;
         if (it.load_aim_x != 0 || it.load_aim_y != 0) begin
            aim_x = it.load_aim_x;
            aim_y = it.load_aim_y;
         end
      end else begin
         sx     = it.stick_x;
         sy     = -int'(it.stick_y);
         rad_sq = longint'(sx * sx + sy * sy);
         if (rad_sq != 0 && rad_sq >= longint'(cfg_aim_dz * cfg_aim_dz)) begin
            aim_x = fit_axis(sx, rad_sq);
            aim_y = fit_axis(sy, rad_sq);
         end
         dir = 0;
         if (it.buttons[BTN_LEFT] || sx <= -int'(cfg_move_dz))
            dir--;
         if (it.buttons[BTN_RIGHT] || sx >= int'(cfg_move_dz))
            dir++;
         fire_cnt   = press_count(fire_cnt, it.buttons[BTN_B]);
         weapon_cnt = press_count(weapon_cnt, it.buttons[BTN_R]);
         r.direction    = DIR_W'(dir);
         r.target_x     = aim_x;
         r.target_y     = aim_y;
         r.jump         = it.buttons[BTN_A];
         r.hook         = it.buttons[BTN_Z];
         r.fire_count   = fire_cnt;
         r.weapon_count = weapon_cnt;
         gives          = 1'b1;
      end
   endtask

   // --- item builders -------------------------------------------------------

   function automatic req_payload_type sample(input logic [BTN_W-1:0] btn,
                                              input int sx, input int sy);
      req_payload_type it;
      it.opcode      = OP_APPLY;
      it.buttons     = btn;
      it.stick_x     = STICK_W'(sx);
      it.stick_y     = STICK_W'(sy);
      // ignored on a sample, but keeps their bits moving
      it.load_fire   = CNT_W'($urandom);
      it.load_weapon = CNT_W'($urandom);
      it.load_aim_x  = AIM_W'($urandom);
      it.load_aim_y  = AIM_W'($urandom);
      return it;
   endfunction

   function automatic req_payload_type adopt(input logic [CNT_W-1:0] f, input logic [CNT_W-1:0] w,
                                             input int ax, input int ay);
      req_payload_type it;
      it             = sample(BTN_W'($urandom), $urandom_range(0, 255), $urandom_range(0, 255));
      it.opcode      = OP_ADOPT;
      it.load_fire   = f;
      it.load_weapon = w;
      it.load_aim_x  = AIM_W'(ax);
      it.load_aim_y  = AIM_W'(ay);
      return it;
   endfunction

   function automatic rsp_payload_type outcome(input logic [DIR_W-1:0] dir, input int tx,
                                               input int ty, input bit j, input bit h,
                                               input logic [CNT_W-1:0] f,
                                               input logic [CNT_W-1:0] w);
      rsp_payload_type r;
      r.direction    = dir;
      r.target_x     = AIM_W'(tx);
      r.target_y     = AIM_W'(ty);
      r.jump         = j;
      r.hook         = h;
      r.fire_count   = f;
      r.weapon_count = w;
      return r;
   endfunction

   function automatic plan_row_type row_retune(input int unsigned dz, input int unsigned md,
                                               input int unsigned len);
      plan_row_type row;
      row        = '{default: '0};
      row.retune = 1'b1;
      row.dz     = dz;
      row.md     = md;
      row.len    = len;
      return row;
   endfunction

   function automatic plan_row_type row_free(input req_payload_type it);
      plan_row_type row;
      row      = '{default: '0};
      row.item = it;
      return row;
   endfunction

   function automatic plan_row_type row_known(input req_payload_type it,
                                              input rsp_payload_type want);
      plan_row_type row;
      row       = row_free(it);
      row.known = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic int clip_stick(input int v);
      return (v < -128) ? -128 : ((v > 127) ? 127 : v);
   endfunction

   // mostly samples, part of them aimed at the deadzone edges; some adopt items
   function automatic req_payload_type random_item();
      req_payload_type it;
      int              pick;
      int              span;
      int              sx;
      int              sy;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0)
         held_buttons = BTN_W'($urandom);
      sx = $urandom_range(0, 255);
      sx = sx - 128;
      sy = $urandom_range(0, 255);
      sy = sy - 128;
      if (pick < 18) begin
         span = cfg_aim_dz + 2;
         sx   = $urandom_range(0, 2 * span);
         sx   = clip_stick(sx - span);
         sy   = $urandom_range(0, 2 * span);
         sy   = clip_stick(sy - span);
      end else if (pick < 32) begin
         span = cfg_move_dz;
         sx   = span + $urandom_range(0, 2);
         sx   = clip_stick(($urandom_range(0, 1) != 0) ? sx - 1 : 1 - sx);
      end else if (pick < 40) begin
         sx = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 127 : -128);
         sy = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 127 : -128);
      end else if (pick < 45) begin
         sx = 0;
         sy = 0;
      end
      it = sample(held_buttons, sx, sy);
      if (pick >= 88) begin
         it = adopt(CNT_W'($urandom), CNT_W'($urandom), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
         if ($urandom_range(0, 3) == 0) begin
            it.load_aim_x = '0;
            it.load_aim_y = '0;
         end else if ($urandom_range(0, 5) == 0) begin
            it.load_aim_x = '0;
         end
      end
      return it;
   endfunction

   // --- drivers -------------------------------------------------------------

   // called just after a falling edge; returns just after a falling edge
   task automatic send_item(input req_payload_type it, input bit known,
                            input rsp_payload_type want);
      bit              gives;
      rsp_payload_type predicted;
      while (gap_left != 0) begin
         req_bus.valid <= 1'b0;
         gap_left--;
         @(negedge clock);
      end
      req_bus.opcode      <= it.opcode;
      req_bus.buttons     <= it.buttons;
      req_bus.stick_x     <= it.stick_x;
      req_bus.stick_y     <= it.stick_y;
      req_bus.load_fire   <= it.load_fire;
      req_bus.load_weapon <= it.load_weapon;
      req_bus.load_aim_x  <= it.load_aim_x;
      req_bus.load_aim_y  <= it.load_aim_y;
      req_bus.valid       <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      condition_item(it, gives, predicted);
      if (gives)
         pending_results.push_back(known ? want : predicted);
      @(negedge clock);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
   endtask

   // hold off until the block has drained and gone quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_regs(input int unsigned dz, input int unsigned md,
                               input int unsigned len);
      csr_we    <= 1'b1;
      csr_index <= CSR_AIM_DEADZONE;
      csr_wdata <= CSR_DATA_W'(dz);
      @(negedge clock);
      csr_index <= CSR_MOVE_DEADZONE;
      csr_wdata <= CSR_DATA_W'(md);
      @(negedge clock);
      csr_index <= CSR_AIM_LENGTH;
      csr_wdata <= CSR_DATA_W'(len);
      @(negedge clock);
      csr_we      <= 1'b0;
      cfg_aim_dz  = dz;
      cfg_move_dz = md;
      cfg_aim_len = len;
   endtask

   // --- result checking -----------------------------------------------------

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_results.size() == 0) begin
         $error("result transfer with nothing expected");
         mismatches++;
      end else begin
         want = pending_results.pop_front();
         check_field("direction", want.direction, got.direction);
         check_field("target_x", want.target_x, got.target_x);
         check_field("target_y", want.target_y, got.target_y);
         check_field("jump", want.jump, got.jump);
         check_field("hook", want.hook, got.hook);
         check_field("fire_count", want.fire_count, got.fire_count);
         check_field("weapon_count", want.weapon_count, got.weapon_count);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed.direction    = rsp_bus.direction;
         observed.target_x     = rsp_bus.target_x;
         observed.target_y     = rsp_bus.target_y;
         observed.jump         = rsp_bus.jump;
         observed.hook         = rsp_bus.hook;
         observed.fire_count   = rsp_bus.fire_count;
         observed.weapon_count = rsp_bus.weapon_count;
         check_result(observed);
      end
   end

   // receiver back-pressure: open, random jitter or a fixed stall wheel
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 2));
         sink_left <= $urandom_range(16, 160);
      end else begin
         sink_left <= sink_left - 1;
      end
      sink_wheel <= {sink_wheel[10:0], sink_wheel[11]};
      case (sink_mode)
         SINK_OPEN:   rsp_bus.ready <= 1'b1;
         SINK_JITTER: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default:     rsp_bus.ready <= sink_wheel[0];
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // --- stimulus ------------------------------------------------------------

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_APPLY;
      req_bus.buttons     = '0;
      req_bus.stick_x     = '0;
      req_bus.stick_y     = '0;
      req_bus.load_fire   = '0;
      req_bus.load_weapon = '0;
      req_bus.load_aim_x  = '0;
      req_bus.load_aim_y  = '0;
      rsp_bus.ready       = 1'b0;

      cfg_aim_dz  = AIM_DZ_RST;
      cfg_move_dz = MOVE_DZ_RST;
      cfg_aim_len = AIM_LEN_RST;
      aim_x       = AIM_X_RST;
      aim_y       = AIM_Y_RST;
      fire_cnt    = '0;
      weapon_cnt  = '0;

      // centred stick keeps the reset aim; all buttons cancel left/right
      directed_plan.push_back(row_known(sample(6'b000000, 0, 0),
                                        outcome(DIR_NONE, 120, 0, 0, 0, 0, 0)));
      directed_plan.push_back(row_known(sample(6'b111111, 0, 0),
                                        outcome(DIR_NONE, 120, 0, 1, 1, 1, 1)));
      // stick extremes on each axis
      directed_plan.push_back(row_known(sample(6'b000000, 127, 0),
                                        outcome(DIR_RIGHT, 120, 0, 0, 0, 2, 2)));
      directed_plan.push_back(row_known(sample(6'b000000, -128, 0),
                                        outcome(DIR_LEFT, -120, 0, 0, 0, 2, 2)));
      directed_plan.push_back(row_known(sample(6'b000000, 0, -128),
                                        outcome(DIR_NONE, 0, 120, 0, 0, 2, 2)));
      directed_plan.push_back(row_known(sample(6'b000000, 0, 127),
                                        outcome(DIR_NONE, 0, -120, 0, 0, 2, 2)));
      // diagonals, inside the aim deadzone, D-pad against the move edge
      directed_plan.push_back(row_free(sample(6'b000100, -128, -128)));
      directed_plan.push_back(row_free(sample(6'b010000, 127, 127)));
      directed_plan.push_back(row_free(sample(6'b001000, 5, 5)));
      directed_plan.push_back(row_free(sample(6'b000001, 0, 0)));
      directed_plan.push_back(row_free(sample(6'b000010, 39, -20)));
      directed_plan.push_back(row_free(sample(6'b100000, 40, 3)));
      directed_plan.push_back(row_free(sample(6'b000010, -40, 0)));
      // adopt with full counters wraps on the next release
      directed_plan.push_back(row_free(adopt(6'd63, 6'd63, 32767, -32768)));
      directed_plan.push_back(row_known(sample(6'b000000, 0, 0),
                                        outcome(DIR_NONE, 32767, -32768, 0, 0, 0, 0)));
      // zero adopted aim leaves the aim alone
      directed_plan.push_back(row_free(adopt(6'd0, 6'd0, 0, 0)));
      directed_plan.push_back(row_known(sample(6'b101000, 0, 0),
                                        outcome(DIR_NONE, 32767, -32768, 0, 0, 1, 1)));
      directed_plan.push_back(row_free(adopt(6'h2a, 6'h15, -1, 0)));
      directed_plan.push_back(row_known(sample(6'b000000, 0, 0),
                                        outcome(DIR_NONE, -1, 0, 0, 0, 42, 22)));
      // zero deadzones and zero aim length
      directed_plan.push_back(row_retune(0, 0, 0));
      directed_plan.push_back(row_known(sample(6'b000000, 0, 0),
                                        outcome(DIR_NONE, -1, 0, 0, 0, 42, 22)));
      directed_plan.push_back(row_known(sample(6'b000000, 1, 0),
                                        outcome(DIR_RIGHT, 0, 0, 0, 0, 42, 22)));
      // widest deadzones, longest aim
      directed_plan.push_back(row_retune(127, 128, 255));
      directed_plan.push_back(row_known(sample(6'b000000, -128, 0),
                                        outcome(DIR_LEFT, -255, 0, 0, 0, 42, 22)));
      directed_plan.push_back(row_known(sample(6'b000000, 127, 0),
                                        outcome(DIR_NONE, 255, 0, 0, 0, 42, 22)));
      directed_plan.push_back(row_free(sample(6'b010100, 100, -60)));
      directed_plan.push_back(row_free(adopt(6'h15, 6'h2a, 16'h5555, 16'haaaa)));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].retune) begin
            settle();
            program_regs(directed_plan[i].dz, directed_plan[i].md, directed_plan[i].len);
         end else begin
            send_item(directed_plan[i].item, directed_plan[i].known, directed_plan[i].want);
         end
      end

      // random phases, each under its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            0:       program_regs(AIM_DZ_RST, MOVE_DZ_RST, AIM_LEN_RST);
            1:       program_regs(0, 128, 255);
            2:       program_regs(127, 0, 1);
            3:       program_regs($urandom_range(0, 40), $urandom_range(0, 128), 0);
            default: program_regs($urandom_range(0, 127), $urandom_range(0, 128),
                                  $urandom_range(1, 255));
         endcase
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      end

      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
sv/jamc_pkg.sv
sv/jamc_req_if.sv
sv/jamc_rsp_if.sv
sv/jamc_ctrl.sv
sv/jamc_dpath.sv
sv/joystick_aim_move_conditioner_unit.sv
test/joystick_aim_move_conditioner_unit_tb.sv
